### sv/hfd_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the heartbeat failure detector.
// No dependencies; used by the channel interfaces and the top level.
package hfd_pkg;

	localparam int WINDOW_LOG2 = 6;
	localparam int WINDOW_SIZE = 1 << WINDOW_LOG2;
	localparam int SLOT_W      = WINDOW_LOG2;
	localparam int FILL_W      = WINDOW_LOG2 + 1;

	localparam int SEQ_W      = 32;
	localparam int TIME_W     = 48;
	localparam int IVL_W      = 24;
	localparam int NORM_W     = 58;
	localparam int SUM_W      = 64;
	localparam int EXP_W      = 58;
	localparam int PROD_W     = SEQ_W + IVL_W;
	localparam int PROD_NXT_W = SEQ_W + 1 + IVL_W;

	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = IVL_W;

	localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MARGIN   = 1'd1;

	localparam logic [IVL_W-1:0] INTERVAL_RESET = 24'd1000000;
	localparam logic [IVL_W-1:0] MARGIN_RESET   = 24'd0;

	localparam logic FUNC_HEARTBEAT = 1'b0;
	localparam logic FUNC_TICK      = 1'b1;

	localparam int OUT_DEPTH = 4;
	localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
	localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

	typedef struct packed {
		logic             client_alive;
		logic             estimate_valid;
		logic [EXP_W-1:0] expected_arrival_us;
		logic             was_fresh;
	} result_t;

endpackage

### sv/hfd_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for heartbeat input and result output.
// Depends on hfd_pkg for field widths.
interface hfd_in_if;
	logic                      valid;
	logic                      ready;
	logic                      func;
	logic [hfd_pkg::SEQ_W-1:0]  seq_num;
	logic [hfd_pkg::TIME_W-1:0] now_us;

	modport source(output valid, func, seq_num, now_us, input ready);
	modport sink(input valid, func, seq_num, now_us, output ready);
endinterface

interface hfd_out_if;
	logic                     valid;
	logic                     ready;
	logic                     client_alive;
	logic                     estimate_valid;
	logic [hfd_pkg::EXP_W-1:0] expected_arrival_us;
	logic                     was_fresh;

	modport source(output valid, client_alive, estimate_valid, expected_arrival_us,
		was_fresh, input ready);
	modport sink(input valid, client_alive, estimate_valid, expected_arrival_us,
		was_fresh, output ready);
endinterface

### sv/hfd_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module hfd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### sv/heartbeat_failure_detector.sv
`timescale 1ns / 1ps
// Heartbeat arrival-time failure detector: ring of normalized arrivals in a RAM,
// running sum, expected-arrival estimate and alive/suspect flag.
// Depends on hfd_pkg, hfd_in_if/hfd_out_if and hfd_ram.
//
// The block takes one heartbeat or tick per cycle while hb.ready is high and
// returns exactly one result per item, in order.
// Stage 0 checks freshness, advances the ring slot and fill count and issues
// the ring read together with both interval products; stage 1 writes the ring
// entry and updates the running sum; stage 2 forms the estimate and updates the
// alive flag. Results queue in a four-entry buffer, and input is taken while
// fewer than four items are unreturned, so a stalled output side stops input
// only after four items. The window mean is an arithmetic shift, so the window
// size is a power of two.
module heartbeat_failure_detector (
	input  logic                           clk,
	input  logic                           arst_n,
	hfd_in_if.sink                         hb,
	hfd_out_if.source                      res,
	input  logic                           cfg_we,
	input  logic [hfd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [hfd_pkg::CFG_DATA_W-1:0] cfg_data
);

	// configuration
	logic [hfd_pkg::IVL_W-1:0] interval_q;
	logic [hfd_pkg::IVL_W-1:0] margin_q;

	// detector state
	logic [hfd_pkg::SUM_W-1:0]  sum_q;
	logic [hfd_pkg::SLOT_W-1:0] slot_q;
	logic [hfd_pkg::FILL_W-1:0] fill_q;
	logic [hfd_pkg::SEQ_W-1:0]  highest_q;
	logic                       any_seen_q;
	logic                       alive_q;
	logic [hfd_pkg::EXP_W-1:0]  expected_q;

	// stage 0
	logic hb_xfer;
	logic fresh0;
	logic full0;
	logic full_after0;

	// stage 1
	logic                           vld_s1;
	logic                           func_s1;
	logic                           fresh_s1;
	logic                           sub_old_s1;
	logic                           full_s1;
	logic [hfd_pkg::TIME_W-1:0]     now_s1;
	logic [hfd_pkg::SLOT_W-1:0]     slot_s1;
	logic [hfd_pkg::PROD_W-1:0]     prod_s1;
	logic [hfd_pkg::PROD_NXT_W-1:0] prod_nxt_s1;
	logic [hfd_pkg::NORM_W-1:0]     norm_s1;
	logic [hfd_pkg::NORM_W-1:0]     old_norm;
	logic [hfd_pkg::SUM_W-1:0]      old_ext;
	logic [hfd_pkg::SUM_W-1:0]      norm_ext;
	logic                           ring_we;

	// stage 2
	logic                           vld_s2;
	logic                           func_s2;
	logic                           fresh_s2;
	logic                           full_s2;
	logic [hfd_pkg::TIME_W-1:0]     now_s2;
	logic [hfd_pkg::PROD_NXT_W-1:0] prod_nxt_s2;
	logic signed [hfd_pkg::SUM_W+1:0] sum_wide;
	logic signed [hfd_pkg::SUM_W+1:0] mean_wide;
	logic signed [hfd_pkg::SUM_W+1:0] est_wide;
	logic [hfd_pkg::EXP_W-1:0]      est;
	logic [hfd_pkg::EXP_W:0]        deadline;
	logic                           late;
	logic                           alive_nxt;
	logic [hfd_pkg::EXP_W-1:0]      expected_nxt;
	hfd_pkg::result_t               result;

	// result buffer
	hfd_pkg::result_t               buf_q [hfd_pkg::OUT_DEPTH];
	logic [hfd_pkg::OUT_PTR_W-1:0]  wr_ptr_q;
	logic [hfd_pkg::OUT_PTR_W-1:0]  rd_ptr_q;
	logic [hfd_pkg::OUT_CNT_W-1:0]  count_q;
	logic [hfd_pkg::OUT_CNT_W-1:0]  inflight_q;
	logic                           res_xfer;

	function automatic logic [hfd_pkg::OUT_CNT_W-1:0] OUT_CNT_ONE(input logic b);
		return {{(hfd_pkg::OUT_CNT_W - 1){1'b0}}, b};
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			interval_q <= hfd_pkg::INTERVAL_RESET;
			margin_q   <= hfd_pkg::MARGIN_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				hfd_pkg::CFG_INTERVAL: interval_q <= cfg_data;
				hfd_pkg::CFG_MARGIN:   margin_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	assign hb.ready = (inflight_q < hfd_pkg::OUT_CNT_W'(hfd_pkg::OUT_DEPTH));
	assign hb_xfer  = hb.valid && hb.ready;
	assign fresh0   = (hb.func == hfd_pkg::FUNC_HEARTBEAT) &&
		(!any_seen_q || (hb.seq_num > highest_q));
	assign full0       = (fill_q == hfd_pkg::FILL_W'(hfd_pkg::WINDOW_SIZE));
	assign full_after0 = full0 ||
		(fresh0 && (fill_q == hfd_pkg::FILL_W'(hfd_pkg::WINDOW_SIZE - 1)));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q     <= '0;
			fill_q     <= '0;
			highest_q  <= '0;
			any_seen_q <= 1'b0;
			vld_s1     <= 1'b0;
		end else begin
			vld_s1 <= hb_xfer;
			if (hb_xfer && fresh0) begin
				highest_q  <= hb.seq_num;
				any_seen_q <= 1'b1;
				slot_q     <= slot_q + 1'b1;
				if (!full0) begin
					fill_q <= fill_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (hb_xfer) begin
			func_s1     <= hb.func;
			fresh_s1    <= fresh0;
			sub_old_s1  <= full0;
			full_s1     <= full_after0;
			now_s1      <= hb.now_us;
			slot_s1     <= slot_q;
			prod_s1     <= hb.seq_num * interval_q;
			prod_nxt_s1 <= ({1'b0, hb.seq_num} + 1'b1) * interval_q;
		end
	end

	hfd_ram #(
		.WIDTH(hfd_pkg::NORM_W),
		.DEPTH(hfd_pkg::WINDOW_SIZE)
	) u_ring (
		.clk  (clk),
		.we   (ring_we),
		.waddr(slot_s1),
		.wdata(norm_s1),
		.raddr(slot_q),
		.rdata(old_norm)
	);

	assign ring_we  = vld_s1 && fresh_s1;
	assign norm_s1  = {{(hfd_pkg::NORM_W - hfd_pkg::TIME_W){1'b0}}, now_s1} -
		{{(hfd_pkg::NORM_W - hfd_pkg::PROD_W){1'b0}}, prod_s1};
	assign norm_ext = {{(hfd_pkg::SUM_W - hfd_pkg::NORM_W){norm_s1[hfd_pkg::NORM_W-1]}},
		norm_s1};
	assign old_ext  = sub_old_s1 ?
		{{(hfd_pkg::SUM_W - hfd_pkg::NORM_W){old_norm[hfd_pkg::NORM_W-1]}}, old_norm} :
		'0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q  <= '0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
			if (ring_we) begin
				sum_q <= sum_q - old_ext + norm_ext;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s1) begin
			func_s2     <= func_s1;
			fresh_s2    <= fresh_s1;
			full_s2     <= full_s1;
			now_s2      <= now_s1;
			prod_nxt_s2 <= prod_nxt_s1;
		end
	end

	// sum_q already holds this item's update while it sits in stage 2
	assign sum_wide  = {{2{sum_q[hfd_pkg::SUM_W-1]}}, sum_q};
	assign mean_wide = sum_wide >>> hfd_pkg::WINDOW_LOG2;
	assign est_wide  = $signed({{(hfd_pkg::SUM_W + 2 - hfd_pkg::PROD_NXT_W){1'b0}},
		prod_nxt_s2}) + mean_wide;
	assign est       = est_wide[hfd_pkg::SUM_W+1] ? '0 : est_wide[hfd_pkg::EXP_W-1:0];
	assign deadline  = {1'b0, expected_q} +
		{{(hfd_pkg::EXP_W + 1 - hfd_pkg::IVL_W){1'b0}}, margin_q};
	assign late      = {{(hfd_pkg::EXP_W + 1 - hfd_pkg::TIME_W){1'b0}}, now_s2} > deadline;

	always_comb begin
		alive_nxt    = alive_q;
		expected_nxt = expected_q;
		if (fresh_s2) begin
			alive_nxt = 1'b1;
			if (full_s2) begin
				expected_nxt = est;
			end
		end else if ((func_s2 == hfd_pkg::FUNC_TICK) && full_s2 && late) begin
			alive_nxt = 1'b0;
		end
	end

	assign result.client_alive        = alive_nxt;
	assign result.estimate_valid      = full_s2;
	assign result.expected_arrival_us = expected_nxt;
	assign result.was_fresh           = fresh_s2;

	assign res_xfer = res.valid && res.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alive_q    <= 1'b0;
			expected_q <= '0;
			wr_ptr_q   <= '0;
			rd_ptr_q   <= '0;
			count_q    <= '0;
			inflight_q <= '0;
		end else begin
			if (vld_s2) begin
				alive_q    <= alive_nxt;
				expected_q <= expected_nxt;
				wr_ptr_q   <= wr_ptr_q + 1'b1;
			end
			if (res_xfer) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			count_q    <= count_q + OUT_CNT_ONE(vld_s2) - OUT_CNT_ONE(res_xfer);
			inflight_q <= inflight_q + OUT_CNT_ONE(hb_xfer) - OUT_CNT_ONE(res_xfer);
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s2) begin
			buf_q[wr_ptr_q] <= result;
		end
	end

	assign res.valid               = (count_q != '0);
	assign res.client_alive        = buf_q[rd_ptr_q].client_alive;
	assign res.estimate_valid      = buf_q[rd_ptr_q].estimate_valid;
	assign res.expected_arrival_us = buf_q[rd_ptr_q].expected_arrival_us;
	assign res.was_fresh           = buf_q[rd_ptr_q].was_fresh;

endmodule

### sim/tb_heartbeat_failure_detector.sv
`timescale 1ns / 1ps
// Testbench for heartbeat_failure_detector: a directed table, then paced and broken heartbeat
// and tick traffic over several interval/margin settings, checked against an in-bench predictor.
// Depends on hfd_pkg, hfd_in_if/hfd_out_if and the heartbeat_failure_detector RTL.
module tb_heartbeat_failure_detector;
	import hfd_pkg::*;

	localparam int CLK_HALF    = 6;
	localparam int N_PHASES    = 5;
	localparam int PHASE_ITEMS = 350;

	localparam logic [SEQ_W-1:0]  S_MAX = '1;
	localparam logic [TIME_W-1:0] T_MAX = '1;

	localparam logic [IVL_W-1:0] PH_IVL [N_PHASES] =
		'{24'd1, 24'hFFFFFF, 24'd1000, 24'd0, 24'd250000};
	localparam logic [IVL_W-1:0] PH_MARGIN [N_PHASES] =
		'{24'd0, 24'hFFFFFF, 24'd20, 24'd5, 24'd100000};
	localparam logic [SEQ_W-1:0] PH_SEQ [N_PHASES] =
		'{32'd16, 32'h0100_0000, 32'h0200_0000, 32'h7FFF_FF00, 32'hFFFF_0000};
	localparam bit PH_PACED [N_PHASES] = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b1};

	typedef struct packed {
		logic              func;
		logic [SEQ_W-1:0]  seq;
		logic [TIME_W-1:0] now;
		logic              typed;
		result_t           want;
	} stim_row_t;

	localparam stim_row_t DIR_ROWS [15] = '{
		'{FUNC_TICK,      32'd0,           48'd0,            1'b1, {1'b0, 1'b0, 58'd0, 1'b0}},
		'{FUNC_TICK,      S_MAX,           T_MAX,            1'b1, {1'b0, 1'b0, 58'd0, 1'b0}},
		'{FUNC_HEARTBEAT, 32'd0,           48'd0,            1'b1, {1'b1, 1'b0, 58'd0, 1'b1}},
		'{FUNC_HEARTBEAT, 32'd0,           48'd7,            1'b1, {1'b1, 1'b0, 58'd0, 1'b0}},
		'{FUNC_TICK,      32'h5A5A_5A5A,   T_MAX,            1'b1, {1'b1, 1'b0, 58'd0, 1'b0}},
		'{FUNC_HEARTBEAT, 32'd1,           48'd1000000,      1'b1, {1'b1, 1'b0, 58'd0, 1'b1}},
		'{FUNC_HEARTBEAT, 32'd0,           48'd999,          1'b1, {1'b1, 1'b0, 58'd0, 1'b0}},
		'{FUNC_HEARTBEAT, 32'd2,           T_MAX,            1'b1, {1'b1, 1'b0, 58'd0, 1'b1}},
		'{FUNC_HEARTBEAT, 32'd5,           48'd0,            1'b1, {1'b1, 1'b0, 58'd0, 1'b1}},
		'{FUNC_HEARTBEAT, 32'd4,           48'd123,          1'b1, {1'b1, 1'b0, 58'd0, 1'b0}},
		'{FUNC_HEARTBEAT, 32'd6,           48'h0000_0123_4567, 1'b0, 61'd0},
		'{FUNC_HEARTBEAT, 32'd9,           48'h8000_0000_0000, 1'b0, 61'd0},
		'{FUNC_TICK,      32'hA5A5_A5A5,   48'h5555_5555_5555, 1'b0, 61'd0},
		'{FUNC_HEARTBEAT, 32'd9,           48'd1,            1'b1, {1'b1, 1'b0, 58'd0, 1'b0}},
		'{FUNC_HEARTBEAT, 32'd10,          48'd10000000,     1'b0, 61'd0}
	};

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  no_idle = 1'b0;

	hfd_in_if  hb();
	hfd_out_if res();

	heartbeat_failure_detector u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.hb        (hb),
		.res       (res),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// predictor state
	logic [NORM_W-1:0] norm_ring [WINDOW_SIZE];
	logic [SUM_W-1:0]  ring_sum    = '0;
	logic [SLOT_W-1:0] ring_slot   = '0;
	logic [FILL_W-1:0] ring_fill   = '0;
	logic [SEQ_W-1:0]  top_seq     = '0;
	logic              seen_any    = 1'b0;
	logic              alive       = 1'b0;
	logic [EXP_W-1:0]  est_arrival = '0;
	logic [IVL_W-1:0]  ivl_cfg     = INTERVAL_RESET;
	logic [IVL_W-1:0]  margin_cfg  = MARGIN_RESET;

	result_t expected_status [$];
	int      errors = 0;
	int      n_fresh = 0;
	int      n_stale = 0;
	int      n_ticks = 0;
	int      n_down = 0;
	int      n_clamped = 0;

	always #(CLK_HALF) clk = ~clk;

	function automatic result_t predict_status(input logic func, input logic [SEQ_W-1:0] seq,
		input logic [TIME_W-1:0] now);
		logic [63:0] prod;
		logic [63:0] diff;
		logic [63:0] norm;
		logic [63:0] mag;
		logic [63:0] quo;
		logic [63:0] est;
		result_t     r;
		logic        fresh;
		fresh = 1'b0;
		if (func == FUNC_HEARTBEAT) begin
			if (!seen_any || seq > top_seq) begin
				prod = 64'(seq) * 64'(ivl_cfg);
				diff = 64'(now) - prod;
				norm = {{(64 - NORM_W){diff[NORM_W-1]}}, diff[NORM_W-1:0]};
				if (ring_fill >= WINDOW_SIZE)
					ring_sum = ring_sum - {{(64 - NORM_W){norm_ring[ring_slot][NORM_W-1]}},
						norm_ring[ring_slot]};
				else
					ring_fill = ring_fill + 1'b1;
				norm_ring[ring_slot] = norm[NORM_W-1:0];
				ring_sum = ring_sum + norm;
				ring_slot = (ring_slot == SLOT_W'(WINDOW_SIZE - 1)) ? '0 : ring_slot + 1'b1;
				if (ring_fill >= WINDOW_SIZE) begin
					prod = (64'(seq) + 64'd1) * 64'(ivl_cfg);
					if (!ring_sum[63]) begin
						est = prod + ring_sum / 64'(WINDOW_SIZE);
					end else begin
						mag = ~ring_sum + 64'd1;
						quo = (mag + 64'(WINDOW_SIZE) - 64'd1) / 64'(WINDOW_SIZE);
						est = (prod >= quo) ? prod - quo : 64'd0;
					end
					est_arrival = est[EXP_W-1:0];
				end
				seen_any = 1'b1;
				top_seq = seq;
				alive = 1'b1;
				fresh = 1'b1;
			end
		end else if (ring_fill >= WINDOW_SIZE &&
			64'(now) > 64'(est_arrival) + 64'(margin_cfg)) begin
			alive = 1'b0;
		end
		r.client_alive        = alive;
		r.estimate_valid      = (ring_fill >= WINDOW_SIZE);
		r.expected_arrival_us = est_arrival;
		r.was_fresh           = fresh;
		return r;
	endfunction

	task automatic send_item(input logic func, input logic [SEQ_W-1:0] seq,
		input logic [TIME_W-1:0] now, input logic typed, input result_t typed_want);
		result_t pred;
		logic    was_alive;
		if (!no_idle && $urandom_range(0, 4) == 0) begin
			hb.valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(negedge clk);
		end
		hb.valid   <= 1'b1;
		hb.func    <= func;
		hb.seq_num <= seq;
		hb.now_us  <= now;
		do @(posedge clk); while (hb.ready !== 1'b1);
		was_alive = alive;
		pred = predict_status(func, seq, now);
		expected_status.push_back(typed ? typed_want : pred);
		if (func == FUNC_TICK) begin
			n_ticks++;
			if (was_alive && !pred.client_alive)
				n_down++;
		end else if (pred.was_fresh) begin
			n_fresh++;
			if (pred.estimate_valid && pred.expected_arrival_us == '0)
				n_clamped++;
		end else begin
			n_stale++;
		end
		@(negedge clk);
	endtask

	task automatic drain_results();
		hb.valid <= 1'b0;
		do @(negedge clk); while (expected_status.size() != 0);
	endtask

	task automatic set_limits(input logic [IVL_W-1:0] ivl_v, input logic [IVL_W-1:0] margin_v);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_INTERVAL;
		cfg_data  <= ivl_v;
		@(posedge clk);
		ivl_cfg = ivl_v;
		@(negedge clk);
		cfg_index <= CFG_MARGIN;
		cfg_data  <= margin_v;
		@(posedge clk);
		margin_cfg = margin_v;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic check_field(input string name, input logic [63:0] want,
		input logic [63:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, actual %0h", name, want, got);
			errors++;
		end
	endtask

	always @(posedge clk) begin : result_check
		result_t want;
		if (arst_n === 1'b1 && res.valid === 1'b1 && res.ready === 1'b1) begin
			if (expected_status.size() == 0) begin
				$error("result transfer with no expected status pending");
				errors++;
			end else begin
				want = expected_status.pop_front();
				check_field("client_alive", 64'(want.client_alive), 64'(res.client_alive));
				check_field("estimate_valid", 64'(want.estimate_valid),
					64'(res.estimate_valid));
				check_field("expected_arrival_us", 64'(want.expected_arrival_us),
					64'(res.expected_arrival_us));
				check_field("was_fresh", 64'(want.was_fresh), 64'(res.was_fresh));
			end
		end
	end

	initial begin : ready_drive
		int hold;
		hold = 0;
		res.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (arst_n === 1'b1) begin
				if (no_idle) begin
					res.ready <= 1'b1;
				end else if (hold == 0) begin
					if ($urandom_range(0, 3) == 0) begin
						res.ready <= 1'b0;
						hold = $urandom_range(1, 12);
					end else begin
						res.ready <= 1'b1;
						hold = $urandom_range(1, 30);
					end
				end
				if (hold > 0)
					hold--;
			end
		end
	end

	initial begin : timeout
		#(20_000_000);
		$display("DONE: errors detected");
		$finish;
	end

	initial begin : stimulus
		logic             func;
		logic [SEQ_W-1:0] seq;
		logic [63:0]      t64;
		logic [63:0]      base;
		int               pick;
		int               jit;
		hb.valid   = 1'b0;
		hb.func    = FUNC_HEARTBEAT;
		hb.seq_num = '0;
		hb.now_us  = '0;
		cfg_we     = 1'b0;
		cfg_index  = CFG_INTERVAL;
		cfg_data   = '0;
		arst_n     = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (DIR_ROWS[i])
			send_item(DIR_ROWS[i].func, DIR_ROWS[i].seq, DIR_ROWS[i].now, DIR_ROWS[i].typed,
				DIR_ROWS[i].want);
		drain_results();

		for (int p = 0; p < N_PHASES; p++) begin
			set_limits(PH_IVL[p], PH_MARGIN[p]);
			base = {24'd0, 8'($urandom), 32'($urandom)};
			jit = int'(PH_IVL[p] / 4) + 1;
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (p == N_PHASES - 1 && n == PHASE_ITEMS / 2)
					no_idle = 1'b1;
				if (!no_idle && $urandom_range(0, 199) == 0)
					drain_results();
				pick = $urandom_range(0, 99);
				func = FUNC_TICK;
				seq = $urandom;
				t64 = {32'($urandom), 32'($urandom)};
				if (pick < 60 || pick >= 94) begin
					func = FUNC_HEARTBEAT;
					if (top_seq < PH_SEQ[p])
						seq = PH_SEQ[p];
					else if ($urandom_range(0, 19) == 0)
						seq = top_seq + $urandom_range(4, 500);
					else
						seq = top_seq + $urandom_range(1, 3);
					if (pick < 60)
						t64 = PH_PACED[p] ?
							base + 64'(seq) * 64'(PH_IVL[p]) + 64'($urandom_range(0, 2 * jit))
								- 64'(jit) :
							64'($urandom_range(0, 1 << 20));
				end else if (pick < 78) begin
					if (ring_fill >= WINDOW_SIZE)
						t64 = 64'(est_arrival) + 64'(margin_cfg) + 64'($urandom_range(0, 4))
							- 64'd2;
				end else if (pick < 88) begin
					func = FUNC_HEARTBEAT;
					seq = SEQ_W'(t64 % (64'(top_seq) + 64'd1));
				end
				send_item(func, seq, t64[TIME_W-1:0], 1'b0, '0);
			end
			if (p != N_PHASES - 1)
				drain_results();
		end

		send_item(FUNC_HEARTBEAT, S_MAX, T_MAX, 1'b0, '0);
		send_item(FUNC_HEARTBEAT, S_MAX, '0, 1'b0, '0);
		send_item(FUNC_TICK, '0, T_MAX, 1'b0, '0);
		hb.valid <= 1'b0;

		while (expected_status.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);

		$display("Covered %0d heartbeats (%0d fresh, %0d stale) and %0d ticks over %0d settings.",
			n_fresh + n_stale, n_fresh, n_stale, n_ticks, N_PHASES + 1);
		$display("Ticks that marked the client down: %0d; estimates clamped at zero: %0d.",
			n_down, n_clamped);
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
